// ===== design/dnle_pkg.sv =====
// shared types and constants for the dns name label encoder
package dnle_pkg;

    // default sizes
    localparam int MAX_LABEL_DEF = 62;
    localparam int MAX_OUT_DEF   = 1024;

    // fixed field widths
    localparam int BYTE_W = 8;
    localparam int CAP_W  = 11;
    localparam int NEED_W = CAP_W + 1;

    localparam logic [CAP_W-1:0]  CAP_RESET = 11'd1024;
    localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] char_byte;
        logic              name_end;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic [1:0]        status;
    } t_out_item;

    // control shared by every cell of the label chain
    typedef struct packed {
        logic              shift;
        logic [BYTE_W-1:0] char_byte;
    } t_cell_ctl;

endpackage

// ===== design/dnle_cell.sv =====
// one byte cell of the label chain: loads a character or takes its neighbor's byte
module dnle_cell (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  dnle_pkg::t_cell_ctl       i_ctl,
    input  logic [dnle_pkg::BYTE_W-1:0] i_next,
    output logic [dnle_pkg::BYTE_W-1:0] o_byte
);
    import dnle_pkg::*;

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_load) begin
            n_byte = i_ctl.char_byte;
        end else if (i_ctl.shift) begin
            n_byte = i_next;
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

// ===== design/dnle_chain.sv =====
// row of label cells: written at the fill position, drained toward cell 0
module dnle_chain #(
    parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF,
    parameter int CNT_W     = $clog2(MAX_LABEL + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_store,
    input  logic [CNT_W-1:0]            i_store_pos,
    input  dnle_pkg::t_cell_ctl         i_ctl,
    output logic [dnle_pkg::BYTE_W-1:0] o_head
);
    import dnle_pkg::*;

    logic [BYTE_W-1:0] w_byte [MAX_LABEL+1];

    // past the last cell the chain reads zero
    assign w_byte[MAX_LABEL] = '0;

    for (genvar g = 0; g < MAX_LABEL; g++) begin : g_cell
        logic w_load;
        assign w_load = i_store && (i_store_pos == CNT_W'(g));

        dnle_cell u_cell (
            .i_clk  (i_clk),
            .i_load (w_load),
            .i_ctl  (i_ctl),
            .i_next (w_byte[g+1]),
            .o_byte (w_byte[g])
        );
    end

    assign o_head = w_byte[0];

endmodule

// ===== design/dns_name_label_encoder.sv =====
// top level of the dns name label encoder
//
// takes a dotted name one character per transfer and produces its dns wire
// form: a length byte and the label bytes for each label, then a zero byte.
// characters are held in a row of MAX_LABEL byte cells until a dot or the
// end-of-name transfer; a flush drains the row toward cell 0 one byte per
// cycle. a dot is accepted, then the length byte and the label bytes follow,
// and the end transfer adds the zero terminator; the input is stalled while
// a flush runs, because the single output register and the drain of the cell
// row emit one byte per cycle. a stalled output holds the block.
// the emitted byte count is checked against out_capacity (clamped to
// MAX_OUT) before each flush; an overflow or a label longer than MAX_LABEL
// gives one result with a nonzero status and the rest of the name is dropped
// up to its end transfer, which gives no result and starts a fresh name.
// out_capacity is written through i_cfg_wr_en / i_cfg_wr_data, reset 1024,
// and should be written only while the block is idle.
module dns_name_label_encoder #(
    parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF,
    parameter int MAX_OUT   = dnle_pkg::MAX_OUT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_wr_en,
    input  logic [dnle_pkg::CAP_W-1:0] i_cfg_wr_data,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  dnle_pkg::t_in_item         i_in_data,
    // output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output dnle_pkg::t_out_item        o_out_data
);
    import dnle_pkg::*;

    localparam int CNT_W = $clog2(MAX_LABEL + 1);

    // controller states
    localparam logic [1:0] S_IDLE = 2'd0;  // taking characters
    localparam logic [1:0] S_LEN  = 2'd1;  // length byte of the label
    localparam logic [1:0] S_BODY = 2'd2;  // draining label bytes
    localparam logic [1:0] S_TERM = 2'd3;  // zero terminator

    logic [1:0]       r_state,      n_state;
    logic [CNT_W-1:0] r_label_cnt,  n_label_cnt;
    logic [CAP_W-1:0] r_bytes_wr,   n_bytes_wr;
    logic             r_err_seen,   n_err_seen;
    logic             r_end_flush,  n_end_flush;
    logic [CAP_W-1:0] r_capacity;
    logic             r_out_valid,  n_out_valid;
    t_out_item        r_out,        n_out;

    t_cell_ctl         w_cell_ctl;
    logic              w_store;
    logic [BYTE_W-1:0] w_head;
    logic              w_out_free;
    logic              w_in_xfer;
    logic [CAP_W-1:0]  w_cap;
    logic [NEED_W-1:0] w_need_dot;
    logic [NEED_W-1:0] w_need_end;

    // capacity above MAX_OUT acts as MAX_OUT
    assign w_cap = (r_capacity > CAP_W'(MAX_OUT)) ? CAP_W'(MAX_OUT) : r_capacity;

    // bytes after a flush of the held label, and after the whole name
    assign w_need_dot = {1'b0, r_bytes_wr} + NEED_W'(r_label_cnt) + NEED_W'(1);
    assign w_need_end = (r_label_cnt != '0) ? w_need_dot + NEED_W'(1)
                                            : {1'b0, r_bytes_wr} + NEED_W'(1);

    // output register can take a byte this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_out_free);
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_label_cnt = r_label_cnt;
        n_bytes_wr  = r_bytes_wr;
        n_err_seen  = r_err_seen;
        n_end_flush = r_end_flush;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_store     = 1'b0;
        w_cell_ctl  = '{shift: 1'b0, char_byte: i_in_data.char_byte};

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (i_in_data.name_end) begin
                        n_bytes_wr = '0;
                        n_err_seen = 1'b0;
                        if (!r_err_seen) begin
                            if (w_need_end > {1'b0, w_cap}) begin
                                n_out_valid = 1'b1;
                                n_out       = '{out_byte: '0, run_last: 1'b1,
                                                status: ST_OVERFLOW};
                                n_label_cnt = '0;
                            end else if (r_label_cnt != '0) begin
                                // label still held, flush then terminate
                                n_end_flush = 1'b1;
                                n_state     = S_LEN;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out       = '{out_byte: '0, run_last: 1'b1,
                                                status: ST_OK};
                            end
                        end else begin
                            n_label_cnt = '0;
                        end
                    end else if (!r_err_seen) begin
                        if (i_in_data.char_byte == DOT_CHAR) begin
                            if (w_need_dot > {1'b0, w_cap}) begin
                                n_err_seen  = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = '{out_byte: '0, run_last: 1'b1,
                                                status: ST_OVERFLOW};
                            end else begin
                                n_bytes_wr  = w_need_dot[CAP_W-1:0];
                                n_end_flush = 1'b0;
                                n_state     = S_LEN;
                            end
                        end else if (r_label_cnt >= CNT_W'(MAX_LABEL)) begin
                            n_err_seen  = 1'b1;
                            n_out_valid = 1'b1;
                            n_out       = '{out_byte: '0, run_last: 1'b1,
                                            status: ST_TOO_LONG};
                        end else begin
                            // character goes into the cell at the fill position
                            w_store     = 1'b1;
                            n_label_cnt = r_label_cnt + CNT_W'(1);
                        end
                    end
                end
            end
            S_LEN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: BYTE_W'(r_label_cnt),
                                    run_last: !r_end_flush && (r_label_cnt == '0),
                                    status: ST_OK};
                    n_state     = (r_label_cnt != '0) ? S_BODY : S_IDLE;
                end
            end
            S_BODY: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out            = '{out_byte: w_head,
                                         run_last: !r_end_flush
                                                   && (r_label_cnt == CNT_W'(1)),
                                         status: ST_OK};
                    w_cell_ctl.shift = 1'b1;
                    n_label_cnt      = r_label_cnt - CNT_W'(1);
                    if (r_label_cnt == CNT_W'(1)) begin
                        n_state = r_end_flush ? S_TERM : S_IDLE;
                    end
                end
            end
            S_TERM: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: '0, run_last: 1'b1, status: ST_OK};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_label_cnt <= '0;
            r_bytes_wr  <= '0;
            r_err_seen  <= 1'b0;
            r_out_valid <= 1'b0;
            r_capacity  <= CAP_RESET;
        end else begin
            r_state     <= n_state;
            r_label_cnt <= n_label_cnt;
            r_bytes_wr  <= n_bytes_wr;
            r_err_seen  <= n_err_seen;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_end_flush <= n_end_flush;
        r_out       <= n_out;
    end

    dnle_chain #(
        .MAX_LABEL (MAX_LABEL),
        .CNT_W     (CNT_W)
    ) u_chain (
        .i_clk       (i_clk),
        .i_store     (w_store),
        .i_store_pos (r_label_cnt),
        .i_ctl       (w_cell_ctl),
        .o_head      (w_head)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // held label never outgrows the cell row
    a_label_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_label_cnt <= CNT_W'(MAX_LABEL))
        else $error("label count beyond cell row");

    // an error result is a single zero byte closing the transfer group
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK))
        |-> (o_out_data.run_last && (o_out_data.out_byte == '0)))
        else $error("error result malformed");

    // end transfer always starts a fresh name
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in_data.name_end) |=> (!r_err_seen && (r_bytes_wr == '0)))
        else $error("name state not cleared at end");

    // body drain only runs with bytes left in the row
    a_body_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BODY) |-> (r_label_cnt != '0))
        else $error("drain with empty label");

    // a stalled output transfer holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output changed");

endmodule
